### rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and register codes for the barometric pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

	typedef enum logic [1:0] {
		CFG_CAL_A   = 2'd0,
		CFG_CAL_B   = 2'd1,
		CFG_CAL_C   = 2'd2,
		CFG_OSS     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [18:0] raw_pressure;
	} in_word_t;

	typedef struct packed {
		logic signed [12:0] temp_tenths;
		logic [17:0]        pressure_pa;
		logic               divide_error;
	} out_word_t;

	// one restoring divide step: dividend bits shift out the top, quotient in the bottom
	typedef struct packed {
		logic [31:0] num;
		logic [19:0] den;
		logic [19:0] rem;
	} div_t;

	localparam int NUM_CELLS = 32;

	localparam int ST_S1   = 0;
	localparam int ST_S2   = 1;
	localparam int ST_T0   = 2;
	localparam int ST_S3   = ST_T0 + NUM_CELLS;
	localparam int ST_S4   = ST_S3 + 1;
	localparam int ST_S5   = ST_S4 + 1;
	localparam int ST_S6   = ST_S5 + 1;
	localparam int ST_S7   = ST_S6 + 1;
	localparam int ST_S8   = ST_S7 + 1;
	localparam int ST_S9   = ST_S8 + 1;
	localparam int ST_P0   = ST_S9 + 1;
	localparam int ST_S10  = ST_P0 + NUM_CELLS;
	localparam int ST_S11  = ST_S10 + 1;
	localparam int ST_S12  = ST_S11 + 1;
	localparam int ST_OUT  = ST_S12 + 1;
	localparam int NUM_ST  = ST_OUT + 1;

	localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
	localparam logic [31:0]        B7_SCALE    = 32'd50000;
	localparam logic [31:0]        B4_BIAS     = 32'd32768;
	localparam logic [35:0]        P_SQ_COEF   = 36'd3038;
	localparam logic signed [46:0] P_LIN_COEF  = -47'sd7357;
	localparam logic signed [46:0] P_OFFSET    = 47'sd3791;
	localparam logic signed [25:0] T_MIN       = -26'sd4096;
	localparam logic signed [25:0] T_MAX       = 26'sd4095;
	localparam logic signed [47:0] P_MAX       = 48'sd262143;

endpackage

`default_nettype wire

### rtl/core/bpc_div_cell.sv
// ----------------------------------------------------------------------------
// bpc_div_cell
// One restoring division step: takes one dividend bit into the partial
// remainder, emits one quotient bit, hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_div_cell (
	input  wire logic          clk,
	input  wire logic          load,
	input  wire bpc_pkg::div_t d,
	output bpc_pkg::div_t      q
);

	logic [20:0] rem_sh;
	logic [20:0] den_x;
	logic        ge;
	logic [20:0] diff;

	assign rem_sh = {d.rem, d.num[31]};
	assign den_x  = {1'b0, d.den};
	assign ge     = (rem_sh >= den_x);
	assign diff   = rem_sh - den_x;

	always_ff @(posedge clk) begin
		if (load) begin
			q.num <= {d.num[30:0], ge};
			q.den <= d.den;
			q.rem <= ge ? diff[19:0] : rem_sh[19:0];
		end
	end

endmodule

`default_nettype wire

### rtl/core/baro_pressure_temp_compensation.sv
// Throughput: one word per cycle while out_ready accepts results;
// stalls only propagate back through full stages.
// The two dividers are chains of 32 one-bit cells each and set the depth.
// Reset clears all stage valid bits and the calibration registers to zero.
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Integer temperature and pressure compensation from calibration coefficients,
// fully pipelined with bit-per-cell dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_pressure_temp_compensation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bpc_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output bpc_pkg::out_word_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	typedef struct packed {
		logic signed [18:0] x1;
		logic [18:0]        up;
	} st1_t;

	typedef struct packed {
		logic signed [18:0] x1;
		logic [18:0]        up;
		logic               neg;
		logic               errt;
	} tside_t;

	typedef struct packed {
		logic signed [29:0] b6;
		logic signed [12:0] t;
		logic [18:0]        up;
		logic               err;
	} st3_t;

	typedef struct packed {
		logic [47:0]        sq;
		logic signed [34:0] a2;
		logic signed [32:0] a3;
		logic signed [12:0] t;
		logic [18:0]        up;
		logic               err;
	} st4_t;

	typedef struct packed {
		logic signed [40:0] pb2h;
		logic signed [40:0] pb2l;
		logic signed [40:0] pb1h;
		logic signed [40:0] pb1l;
		logic signed [34:0] a2;
		logic signed [32:0] a3;
		logic signed [12:0] t;
		logic [18:0]        up;
		logic               err;
	} st5_t;

	typedef struct packed {
		logic signed [54:0] x1;
		logic signed [49:0] y2;
		logic signed [34:0] a2;
		logic signed [32:0] a3;
		logic signed [12:0] t;
		logic [18:0]        up;
		logic               err;
	} st6_t;

	typedef struct packed {
		logic [31:0]        b3;
		logic [31:0]        xx;
		logic signed [12:0] t;
		logic [18:0]        up;
		logic               err;
	} st7_t;

	typedef struct packed {
		logic [16:0]        b4;
		logic [31:0]        b7;
		logic signed [12:0] t;
		logic               err;
	} st8_t;

	typedef struct packed {
		logic signed [12:0] t;
		logic               err;
		logic               lt;
		logic               perr;
	} pside_t;

	typedef struct packed {
		logic [31:0]        q;
		logic [47:0]        sq8;
		logic signed [30:0] x2;
		logic signed [12:0] t;
		logic               err;
		logic               perr;
	} st10_t;

	typedef struct packed {
		logic [35:0]        mh;
		logic [35:0]        ml;
		logic [31:0]        q;
		logic signed [30:0] x2;
		logic signed [12:0] t;
		logic               err;
		logic               perr;
	} st11_t;

	typedef struct packed {
		logic [44:0]        x1;
		logic [31:0]        q;
		logic signed [30:0] x2;
		logic signed [12:0] t;
		logic               err;
		logic               perr;
	} st12_t;

	// calibration
	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;

	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_valid) begin
			unique case (bpc_pkg::cfg_reg_t'(cfg_index))
				bpc_pkg::CFG_CAL_A: cal_a_q <= cfg_data;
				bpc_pkg::CFG_CAL_B: cal_b_q <= cfg_data;
				bpc_pkg::CFG_CAL_C: cal_c_q <= cfg_data[31:0];
				bpc_pkg::CFG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ac1 = $signed(cal_a_q[15:0]);
	assign ac2 = $signed(cal_a_q[31:16]);
	assign ac3 = $signed(cal_a_q[47:32]);
	assign ac4 = cal_a_q[63:48];
	assign ac5 = cal_b_q[15:0];
	assign ac6 = cal_b_q[31:16];
	assign b1  = $signed(cal_b_q[47:32]);
	assign b2  = $signed(cal_b_q[63:48]);
	assign mc  = $signed(cal_c_q[15:0]);
	assign md  = $signed(cal_c_q[31:16]);

	// stall chain
	logic [bpc_pkg::NUM_ST-1:0] vld_q;
	logic [bpc_pkg::NUM_ST-1:0] load;
	logic [bpc_pkg::NUM_ST-1:0] vld_prev;

	assign load[bpc_pkg::NUM_ST-1] = ~vld_q[bpc_pkg::NUM_ST-1] | out_ready;
	for (genvar k = 0; k < bpc_pkg::NUM_ST - 1; k++) begin : g_load
		assign load[k] = ~vld_q[k] | load[k+1];
	end

	assign vld_prev = {vld_q[bpc_pkg::NUM_ST-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < bpc_pkg::NUM_ST; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_prev[k];
				end
			end
		end
	end

	assign in_ready  = load[bpc_pkg::ST_S1];
	assign out_valid = vld_q[bpc_pkg::ST_OUT];

	// S1: X1 from UT
	st1_t               p_s1;
	logic signed [16:0] s1_d;
	logic signed [33:0] s1_p;

	assign s1_d = $signed({1'b0, in_data.raw_temp}) - $signed({1'b0, ac6});
	assign s1_p = 34'(s1_d) * 34'($signed({1'b0, ac5}));

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S1]) begin
			p_s1.x1 <= 19'(s1_p >>> 15);
			p_s1.up <= in_data.raw_pressure;
		end
	end

	// S2: temperature divider setup
	bpc_pkg::div_t      t_div [bpc_pkg::NUM_CELLS+1];
	tside_t             t_side [bpc_pkg::NUM_CELLS+1];
	logic signed [19:0] s2_den;
	logic signed [26:0] s2_num;
	logic [26:0]        s2_nmag;
	logic [19:0]        s2_dmag;

	assign s2_den  = 20'(p_s1.x1) + 20'(md);
	assign s2_num  = $signed({mc, 11'b0});
	assign s2_nmag = s2_num[26] ? 27'(-s2_num) : 27'(s2_num);
	assign s2_dmag = s2_den[19] ? 20'(-s2_den) : 20'(s2_den);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S2]) begin
			t_div[0].num   <= {5'b0, s2_nmag};
			t_div[0].den   <= s2_dmag;
			t_div[0].rem   <= '0;
			t_side[0].x1   <= p_s1.x1;
			t_side[0].up   <= p_s1.up;
			t_side[0].neg  <= s2_num[26] ^ s2_den[19];
			t_side[0].errt <= (s2_den == '0);
		end
	end

	for (genvar i = 0; i < bpc_pkg::NUM_CELLS; i++) begin : g_tdiv
		bpc_div_cell u_cell (
			.clk  (clk),
			.load (load[bpc_pkg::ST_T0+i]),
			.d    (t_div[i]),
			.q    (t_div[i+1])
		);

		always_ff @(posedge clk) begin
			if (load[bpc_pkg::ST_T0+i]) begin
				t_side[i+1] <= t_side[i];
			end
		end
	end

	// S3: B5, temperature, B6
	st3_t               p_s3;
	tside_t             s3_sd;
	logic [26:0]        s3_qm;
	logic signed [27:0] s3_x2;
	logic signed [28:0] s3_b5;
	logic signed [25:0] s3_tt;
	logic signed [12:0] s3_t;

	assign s3_sd = t_side[bpc_pkg::NUM_CELLS];
	assign s3_qm = t_div[bpc_pkg::NUM_CELLS].num[26:0];

	always_comb begin
		if (s3_sd.errt) begin
			s3_x2 = '0;
		end else if (s3_sd.neg) begin
			s3_x2 = -$signed({1'b0, s3_qm});
		end else begin
			s3_x2 = $signed({1'b0, s3_qm});
		end
		s3_b5 = 29'(s3_sd.x1) + 29'(s3_x2);
		s3_tt = 26'((30'(s3_b5) + 30'sd8) >>> 4);
		priority if (s3_tt < bpc_pkg::T_MIN) begin
			s3_t = 13'(bpc_pkg::T_MIN);
		end else if (s3_tt > bpc_pkg::T_MAX) begin
			s3_t = 13'(bpc_pkg::T_MAX);
		end else begin
			s3_t = 13'(s3_tt);
		end
	end

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S3]) begin
			p_s3.b6  <= 30'(s3_b5) - bpc_pkg::B6_OFFSET;
			p_s3.t   <= s3_t;
			p_s3.up  <= s3_sd.up;
			p_s3.err <= s3_sd.errt;
		end
	end

	// S4: B6 squared, linear terms
	st4_t               p_s4;
	logic signed [59:0] s4_sq;
	logic signed [45:0] s4_a2;
	logic signed [45:0] s4_a3;

	assign s4_sq = 60'(p_s3.b6) * 60'(p_s3.b6);
	assign s4_a2 = 46'(ac2) * 46'(p_s3.b6);
	assign s4_a3 = 46'(ac3) * 46'(p_s3.b6);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S4]) begin
			p_s4.sq  <= s4_sq[59:12];
			p_s4.a2  <= 35'(s4_a2 >>> 11);
			p_s4.a3  <= 33'(s4_a3 >>> 13);
			p_s4.t   <= p_s3.t;
			p_s4.up  <= p_s3.up;
			p_s4.err <= p_s3.err;
		end
	end

	// S5: b1, b2 times sq as partial products
	st5_t               p_s5;
	logic signed [24:0] s5_sh;
	logic signed [24:0] s5_sl;

	assign s5_sh = $signed({1'b0, p_s4.sq[47:24]});
	assign s5_sl = $signed({1'b0, p_s4.sq[23:0]});

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S5]) begin
			p_s5.pb2h <= 41'(b2) * 41'(s5_sh);
			p_s5.pb2l <= 41'(b2) * 41'(s5_sl);
			p_s5.pb1h <= 41'(b1) * 41'(s5_sh);
			p_s5.pb1l <= 41'(b1) * 41'(s5_sl);
			p_s5.a2   <= p_s4.a2;
			p_s5.a3   <= p_s4.a3;
			p_s5.t    <= p_s4.t;
			p_s5.up   <= p_s4.up;
			p_s5.err  <= p_s4.err;
		end
	end

	// S6: combine partial products
	st6_t               p_s6;
	logic signed [65:0] s6_b2sq;
	logic signed [65:0] s6_b1sq;

	assign s6_b2sq = (66'(p_s5.pb2h) <<< 24) + 66'(p_s5.pb2l);
	assign s6_b1sq = (66'(p_s5.pb1h) <<< 24) + 66'(p_s5.pb1l);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S6]) begin
			p_s6.x1  <= 55'(s6_b2sq >>> 11);
			p_s6.y2  <= 50'(s6_b1sq >>> 16);
			p_s6.a2  <= p_s5.a2;
			p_s6.a3  <= p_s5.a3;
			p_s6.t   <= p_s5.t;
			p_s6.up  <= p_s5.up;
			p_s6.err <= p_s5.err;
		end
	end

	// S7: B3 and B4 operand
	st7_t               p_s7;
	logic signed [55:0] s7_x3;
	logic signed [56:0] s7_bsum;
	logic signed [60:0] s7_v;
	logic signed [61:0] s7_b3;
	logic signed [50:0] s7_s;
	logic signed [50:0] s7_x3b;

	always_comb begin
		s7_x3   = 56'(p_s6.x1) + 56'(p_s6.a2);
		s7_bsum = (57'(ac1) <<< 2) + 57'(s7_x3);
		s7_v    = (61'(s7_bsum) <<< oss_q) + 61'sd2;
		if (s7_v[60]) begin
			s7_b3 = (62'(s7_v) + 62'sd3) >>> 2;
		end else begin
			s7_b3 = 62'(s7_v) >>> 2;
		end
		s7_s   = 51'(p_s6.a3) + 51'(p_s6.y2) + 51'sd2;
		s7_x3b = s7_s >>> 2;
	end

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S7]) begin
			p_s7.b3  <= s7_b3[31:0];
			p_s7.xx  <= s7_x3b[31:0] + bpc_pkg::B4_BIAS;
			p_s7.t   <= p_s6.t;
			p_s7.up  <= p_s6.up;
			p_s7.err <= p_s6.err;
		end
	end

	// S8: B4, B7
	st8_t        p_s8;
	logic [47:0] s8_pa;
	logic [31:0] s8_dif;
	logic [15:0] s8_mul;
	logic [47:0] s8_pb;

	assign s8_pa  = 48'(ac4) * 48'(p_s7.xx);
	assign s8_dif = {13'b0, p_s7.up} - p_s7.b3;
	assign s8_mul = 16'(bpc_pkg::B7_SCALE >> oss_q);
	assign s8_pb  = 48'(s8_dif) * 48'(s8_mul);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S8]) begin
			p_s8.b4  <= s8_pa[31:15];
			p_s8.b7  <= s8_pb[31:0];
			p_s8.t   <= p_s7.t;
			p_s8.err <= p_s7.err;
		end
	end

	// S9: pressure divider setup
	bpc_pkg::div_t p_div [bpc_pkg::NUM_CELLS+1];
	pside_t        p_side [bpc_pkg::NUM_CELLS+1];
	logic          s9_lt;
	logic          s9_perr;

	assign s9_lt   = ~p_s8.b7[31];
	assign s9_perr = (p_s8.b4 == '0);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S9]) begin
			p_div[0].num   <= s9_lt ? {p_s8.b7[30:0], 1'b0} : p_s8.b7;
			p_div[0].den   <= {3'b0, p_s8.b4};
			p_div[0].rem   <= '0;
			p_side[0].t    <= p_s8.t;
			p_side[0].err  <= p_s8.err | s9_perr;
			p_side[0].lt   <= s9_lt;
			p_side[0].perr <= s9_perr;
		end
	end

	for (genvar i = 0; i < bpc_pkg::NUM_CELLS; i++) begin : g_pdiv
		bpc_div_cell u_cell (
			.clk  (clk),
			.load (load[bpc_pkg::ST_P0+i]),
			.d    (p_div[i]),
			.q    (p_div[i+1])
		);

		always_ff @(posedge clk) begin
			if (load[bpc_pkg::ST_P0+i]) begin
				p_side[i+1] <= p_side[i];
			end
		end
	end

	// S10: quotient, square and linear term
	st10_t              p_s10;
	pside_t             s10_sd;
	logic [31:0]        s10_q0;
	logic [31:0]        s10_q;
	logic signed [46:0] s10_lin;

	assign s10_sd  = p_side[bpc_pkg::NUM_CELLS];
	assign s10_q0  = p_div[bpc_pkg::NUM_CELLS].num;
	assign s10_q   = s10_sd.lt ? s10_q0 : {s10_q0[30:0], 1'b0};
	assign s10_lin = 47'($signed({1'b0, s10_q})) * bpc_pkg::P_LIN_COEF;

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S10]) begin
			p_s10.q    <= s10_q;
			p_s10.sq8  <= 48'(s10_q[31:8]) * 48'(s10_q[31:8]);
			p_s10.x2   <= 31'(s10_lin >>> 16);
			p_s10.t    <= s10_sd.t;
			p_s10.err  <= s10_sd.err;
			p_s10.perr <= s10_sd.perr;
		end
	end

	// S11: quadratic coefficient as partial products
	st11_t p_s11;

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S11]) begin
			p_s11.mh   <= 36'(p_s10.sq8[47:24]) * bpc_pkg::P_SQ_COEF;
			p_s11.ml   <= 36'(p_s10.sq8[23:0]) * bpc_pkg::P_SQ_COEF;
			p_s11.q    <= p_s10.q;
			p_s11.x2   <= p_s10.x2;
			p_s11.t    <= p_s10.t;
			p_s11.err  <= p_s10.err;
			p_s11.perr <= p_s10.perr;
		end
	end

	// S12: combine quadratic term
	st12_t       p_s12;
	logic [60:0] s12_sum;

	assign s12_sum = (61'(p_s11.mh) << 24) + 61'(p_s11.ml);

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_S12]) begin
			p_s12.x1   <= 45'(s12_sum >> 16);
			p_s12.q    <= p_s11.q;
			p_s12.x2   <= p_s11.x2;
			p_s12.t    <= p_s11.t;
			p_s12.err  <= p_s11.err;
			p_s12.perr <= p_s11.perr;
		end
	end

	// output: correction, clamp
	logic signed [46:0] so_c;
	logic signed [47:0] so_p;
	logic [17:0]        so_pa;

	always_comb begin
		so_c = 47'($signed({1'b0, p_s12.x1})) + 47'(p_s12.x2) + bpc_pkg::P_OFFSET;
		so_p = 48'($signed({1'b0, p_s12.q})) + 48'(so_c >>> 4);
		priority if (p_s12.perr) begin
			so_pa = '0;
		end else if (so_p < 48'sd0) begin
			so_pa = '0;
		end else if (so_p > bpc_pkg::P_MAX) begin
			so_pa = 18'(bpc_pkg::P_MAX);
		end else begin
			so_pa = so_p[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load[bpc_pkg::ST_OUT]) begin
			out_data.temp_tenths  <= p_s12.t;
			out_data.pressure_pa  <= so_pa;
			out_data.divide_error <= p_s12.err;
		end
	end

endmodule

`default_nettype wire

### verif/tb_baro_pressure_temp_compensation.sv
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation
// Self-checking bench for the pressure and temperature compensation pipeline.
// A directed table covers reset, the extremes and the divide-by-zero cases.
// Random words under several calibration sets follow, each result compared
// field by field with an integer predictor. Both sides idle at random, and
// the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_baro_pressure_temp_compensation;
	timeunit 1ns;
	timeprecision 1ps;
	import bpc_pkg::*;

	localparam int PIPE_DEPTH = 80;

	typedef struct {
		bit [63:0] a;
		bit [63:0] b;
		bit [31:0] c;
		bit [1:0]  oss;
	} cal_set_t;

	typedef struct {
		int        set;
		bit [15:0] ut;
		bit [18:0] up;
		bit        typed;
		out_word_t want;
	} vec_t;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_word_t out_data;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	bit [63:0] cal_a, cal_b;
	bit [31:0] cal_c;
	bit [1:0]  oss_set;
	out_word_t result_q[$];
	bit        typed_has_q[$];
	out_word_t typed_word_q[$];
	int        fail_count = 0;
	int        words_in = 0;
	int        send_idle = 0, recv_idle = 0;
	int        hold_left = 0;
	bit        hold_done = 0;

	baro_pressure_temp_compensation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic out_word_t compensate(in_word_t w);
		longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
		longint x1, x2, x3, den, b5, b6, b3, sq, t, pr;
		bit [31:0] up, b4, b7, q, x3w, b3w, prod;
		bit err;
		out_word_t r;
		ac1 = longint'($signed(cal_a[15:0]));
		ac2 = longint'($signed(cal_a[31:16]));
		ac3 = longint'($signed(cal_a[47:32]));
		ac4 = longint'(cal_a[63:48]);
		ac5 = longint'(cal_b[15:0]);
		ac6 = longint'(cal_b[31:16]);
		b1 = longint'($signed(cal_b[47:32]));
		b2 = longint'($signed(cal_b[63:48]));
		mc = longint'($signed(cal_c[15:0]));
		md = longint'($signed(cal_c[31:16]));
		ut = longint'(w.raw_temp);
		up = 32'(w.raw_pressure);
		err = 0;
		x1 = ((ut - ac6) * ac5) >>> 15;
		den = x1 + md;
		if (den == 0) begin
			err = 1;
			x2 = 0;
		end else begin
			x2 = (mc * 2048) / den;
		end
		b5 = x1 + x2;
		t = (b5 + 8) >>> 4;
		if (t < -4096) t = -4096;
		if (t > 4095) t = 4095;
		b6 = b5 - 4000;
		sq = (b6 * b6) >>> 12;
		x1 = (b2 * sq) >>> 11;
		x2 = (ac2 * b6) >>> 11;
		x3 = x1 + x2;
		b3 = ((ac1 * 4 + x3) * (longint'(1) << oss_set) + 2) / 4;
		x1 = (ac3 * b6) >>> 13;
		x2 = (b1 * sq) >>> 16;
		x3 = (x1 + x2 + 2) >>> 2;
		x3w = 32'(x3 + 32768);
		prod = ac4[31:0] * x3w;
		b4 = prod >> 15;
		b3w = 32'(b3);
		b7 = (up - b3w) * (32'd50000 >> oss_set);
		if (b4 == 0) begin
			err = 1;
			pr = 0;
		end else begin
			if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
			else q = (b7 / b4) * 32'd2;
			pr = longint'(q);
			x1 = (pr >>> 8) * (pr >>> 8);
			x1 = (x1 * 3038) >>> 16;
			x2 = (-7357 * pr) >>> 16;
			pr = pr + ((x1 + x2 + 3791) >>> 4);
			if (pr < 0) pr = 0;
			if (pr > 262143) pr = 262143;
		end
		r.temp_tenths = t[12:0];
		r.pressure_pa = pr[17:0];
		r.divide_error = err;
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// scoreboard: predict on input accept, compare on output accept
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = compensate(in_data);
				if (typed_has_q.size() > 0) begin
					if (typed_has_q.pop_front()) want = typed_word_q[0];
					void'(typed_word_q.pop_front());
				end
				result_q.push_back(want);
				words_in++;
			end
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					flag_mismatch("word with nothing expected");
				end else begin
					want = result_q.pop_front();
					if (out_data.temp_tenths !== want.temp_tenths)
						flag_mismatch($sformatf("temp_tenths %0d want %0d",
							out_data.temp_tenths, want.temp_tenths));
					if (out_data.pressure_pa !== want.pressure_pa)
						flag_mismatch($sformatf("pressure_pa %0d want %0d",
							out_data.pressure_pa, want.pressure_pa));
					if (out_data.divide_error !== want.divide_error)
						flag_mismatch($sformatf("divide_error %0b want %0b",
							out_data.divide_error, want.divide_error));
				end
			end
		end
	end

	// receiver with one long hold-off midway
	always @(negedge clk) begin
		if (!hold_done && words_in >= 500) begin
			hold_done <= 1;
			hold_left <= 400;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_word(input in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input bit [63:0] val);
		@(negedge clk);
		in_valid <= 0;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CAL_A: cal_a = val;
			CFG_CAL_B: cal_b = val;
			CFG_CAL_C: cal_c = val[31:0];
			CFG_OSS: oss_set = val[1:0];
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic load_cal(input cal_set_t s);
		drain();
		write_reg(CFG_CAL_A, s.a);
		write_reg(CFG_CAL_B, s.b);
		write_reg(CFG_CAL_C, {32'd0, s.c});
		write_reg(CFG_OSS, {62'd0, s.oss});
	endtask

	function automatic cal_set_t jitter_cal(input cal_set_t base, input int bits);
		cal_set_t s;
		s = base;
		s.a ^= {$urandom, $urandom} & {4{16'((1 << bits) - 1)}};
		s.b ^= {$urandom, $urandom} & {4{16'((1 << bits) - 1)}};
		s.c ^= $urandom & {2{16'((1 << bits) - 1)}};
		s.oss = 2'($urandom_range(3));
		return s;
	endfunction

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		cal_set_t sets[3];
		cal_set_t nominal, cur_set;
		vec_t tbl[$];
		out_word_t dead, sheet;
		in_word_t w;
		int cur, n;

		sets[0] = '{64'd0, 64'd0, 32'd0, 2'd0};
		// datasheet example coefficients
		nominal.a = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
		nominal.b = {16'd4, 16'd6190, 16'd23153, 16'd32757};
		nominal.c = {16'd2868, 16'hDDF9};
		nominal.oss = 2'd0;
		sets[1] = nominal;
		sets[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd3};

		dead = '{13'sd0, 18'd0, 1'b1};
		sheet = '{13'sd150, 18'd69964, 1'b0};
		tbl = '{
			'{0, 16'h0000, 19'h00000, 1'b1, dead},
			'{0, 16'hFFFF, 19'h7FFFF, 1'b1, dead},
			'{0, 16'h0000, 19'h7FFFF, 1'b1, dead},
			'{0, 16'hFFFF, 19'h00000, 1'b1, dead},
			'{0, 16'h5555, 19'h2AAAA, 1'b1, dead},
			'{0, 16'hAAAA, 19'h55555, 1'b1, dead},
			'{1, 16'd27898, 19'd23843, 1'b1, sheet},
			'{1, 16'h0000, 19'h00000, 1'b0, dead},
			'{1, 16'hFFFF, 19'h7FFFF, 1'b0, dead},
			'{1, 16'd23153, 19'd40000, 1'b0, dead},
			'{1, 16'd32000, 19'h7FFFF, 1'b0, dead},
			'{1, 16'd15000, 19'd0, 1'b0, dead},
			'{2, 16'h0000, 19'h00000, 1'b0, dead},
			'{2, 16'hFFFF, 19'h7FFFF, 1'b0, dead},
			'{2, 16'hFFFF, 19'h00000, 1'b0, dead},
			'{2, 16'h0000, 19'h7FFFF, 1'b0, dead},
			'{2, 16'h8000, 19'h40000, 1'b0, dead},
			'{2, 16'h7FFF, 19'h3FFFF, 1'b0, dead}
		};

		cal_a = '0;
		cal_b = '0;
		cal_c = '0;
		oss_set = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		cur = 0;
		foreach (tbl[i]) begin
			if (tbl[i].set != cur) begin
				cur = tbl[i].set;
				load_cal(sets[cur]);
			end
			typed_has_q.push_back(tbl[i].typed);
			typed_word_q.push_back(tbl[i].want);
			w.raw_temp = tbl[i].ut;
			w.raw_pressure = tbl[i].up;
			send_word(w);
		end

		for (int seg = 0; seg < 9; seg++) begin
			case (seg)
				0, 1, 2: begin send_idle = 11; recv_idle = 52; end
				3, 4, 5: begin send_idle = 52; recv_idle = 11; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (seg)
				0: cur_set = '{64'd0, {48'd0, 16'd1}, 32'd0, 2'd1};
				4: cur_set = '{{$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'd3};
				7: cur_set = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
					32'hFFFF_FFFF, 2'd0};
				default: cur_set = jitter_cal(nominal, (seg % 3) * 4 + 3);
			endcase
			if (seg == 2) cur_set.oss = 2'd3;
			load_cal(cur_set);
			n = (seg == 3) ? 180 : 115;
			repeat (n) begin
				w.raw_temp = 16'($urandom);
				w.raw_pressure = 19'($urandom);
				if ($urandom_range(3) != 0) begin
					// keep samples near the sensor's normal span
					w.raw_temp = 16'($urandom_range(20000, 36000));
					w.raw_pressure = 19'($urandom_range(15000, 40000) << cur_set.oss);
				end
				send_word(w);
			end
		end

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_div_cell.sv
rtl/core/baro_pressure_temp_compensation.sv
verif/tb_baro_pressure_temp_compensation.sv
